// ----- rtl/trle_pkg.sv -----
// Shared constants for the transparent run-length encoder.
// No dependencies; used by transparent_run_length_encoder.
package trle_pkg;

    localparam int MAX_RUN   = 127;
    localparam int MAX_WIDTH = 4096;

    localparam int PIX_W  = 8;
    localparam int RUN_W  = 7;   // run length 0..MAX_RUN
    localparam int COL_W  = 12;  // column 0..MAX_WIDTH-1
    localparam int CFG_W  = 13;  // row_width register
    localparam int WORD_W = 64;  // packed output word
    localparam int CNT_W  = 4;   // byte count 1..8
    localparam int DATA_W = 72;  // packed bytes + byte count, padded to bytes

    localparam logic [PIX_W-1:0] ROW_END_BYTE = 8'h80;
    localparam logic [PIX_W-1:0] TRANS_FLAG   = 8'h80;

endpackage

// ----- rtl/transparent_run_length_encoder.sv -----
// Transparent run-length encoder: pixel stream in, packed coded bytes out.
// Depends on trle_pkg.
//
//  channel     | dir | handshake                          | payload
//  ------------+-----+------------------------------------+---------------------------------
//  s_axis      | in  | i_s_axis_tvalid / o_s_axis_tready  | tdata[7:0] pixel
//  m_axis      | out | o_m_axis_tvalid / i_m_axis_tready  | tdata[63:0] packed_bytes,
//              |     |                                    | [67:64] byte_count; tlast = last
//  cfg         | in  | i_cfg_wr_en                        | i_cfg_wr_data[12:0] row_width
//
// A pixel is taken while the block is idle. The coded bytes it causes are then produced
// one per cycle, unless the output stalls, through a single byte path (run header, stored
// literal bytes read from the literal memory one address per cycle, row-end byte), so a
// pixel causing bytes holds the input until its last byte has been emitted. A pixel causing
// no bytes leaves the block ready in the next cycle.
// Reset (synchronous, active low) clears control state; the literal memory is not cleared.
module transparent_run_length_encoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [trle_pkg::CFG_W-1:0]       i_cfg_wr_data,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [trle_pkg::PIX_W-1:0]       i_s_axis_tdata,  // [7:0] pixel
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [trle_pkg::DATA_W-1:0]      o_m_axis_tdata,  // [63:0] packed_bytes,
                                                              // [67:64] byte_count, rest 0
    output logic                             o_m_axis_tlast
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_HDR  = 2'd1;
    localparam logic [1:0] S_LIT  = 2'd2;
    localparam logic [1:0] S_EOR  = 2'd3;

    localparam logic [trle_pkg::RUN_W-1:0] RUN_FULL = trle_pkg::RUN_W'(trle_pkg::MAX_RUN);
    localparam logic [trle_pkg::RUN_W-1:0] RUN_TOP  = trle_pkg::RUN_W'(trle_pkg::MAX_RUN - 1);
    localparam logic [trle_pkg::CFG_W-1:0] WIDTH_MAX = trle_pkg::CFG_W'(trle_pkg::MAX_WIDTH);

    // configuration and run state
    logic [trle_pkg::CFG_W-1:0] r_row_width;
    logic [trle_pkg::COL_W-1:0] r_col;
    logic [trle_pkg::RUN_W-1:0] r_run_len;
    logic                       r_run_t;

    // literal store
    logic [trle_pkg::PIX_W-1:0] r_mem [trle_pkg::MAX_RUN];
    logic [trle_pkg::PIX_W-1:0] r_rd;

    // sequencer: current close job and a pending second one
    logic [1:0]                 r_state;
    logic [trle_pkg::PIX_W-1:0] r_hdr;
    logic [trle_pkg::RUN_W-1:0] r_lit_n;
    logic                       r_eor;
    logic [trle_pkg::RUN_W-1:0] r_idx;
    logic                       r_b_pend;
    logic                       r_b_hdr_en;
    logic [trle_pkg::PIX_W-1:0] r_b_hdr;
    logic [trle_pkg::RUN_W-1:0] r_b_lit_n;
    logic                       r_b_eor;

    // byte packer and output register
    logic [trle_pkg::WORD_W-1:0] r_pk;
    logic [2:0]                  r_pk_cnt;
    logic                        r_out_valid;
    logic [trle_pkg::WORD_W-1:0] r_out_data;
    logic [trle_pkg::CNT_W-1:0]  r_out_cnt;
    logic                        r_out_last;

    // accept-side decode
    logic                       accept;
    logic                       pix_t;
    logic [trle_pkg::CFG_W-1:0] eff_width;
    logic                       eol;
    logic                       close_first;
    logic [trle_pkg::RUN_W-1:0] new_len;
    logic                       full;
    logic                       has_b;
    logic [trle_pkg::RUN_W-1:0] wr_addr;
    logic [trle_pkg::PIX_W-1:0] a_hdr;
    logic [trle_pkg::RUN_W-1:0] a_lit_n;
    logic                       b_hdr_en;
    logic [trle_pkg::PIX_W-1:0] b_hdr;
    logic [trle_pkg::RUN_W-1:0] b_lit_n;

    // emit-side decode
    logic                        last_of_job;
    logic                        final_byte;
    logic                        flush;
    logic                        out_free;
    logic                        emit;
    logic [trle_pkg::PIX_W-1:0]  cur_byte;
    logic [trle_pkg::WORD_W-1:0] pk_new;
    logic [trle_pkg::CNT_W-1:0]  cnt_new;
    logic [trle_pkg::RUN_W-1:0]  rd_addr;
    logic [trle_pkg::RUN_W-1:0]  idx_next;
    logic [1:0]                  n_state;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        pix_t = (i_s_axis_tdata == '0);
        if (r_row_width == '0) begin
            eff_width = trle_pkg::CFG_W'(1);
        end else if (r_row_width > WIDTH_MAX) begin
            eff_width = WIDTH_MAX;
        end else begin
            eff_width = r_row_width;
        end
        eol         = (({1'b0, r_col} + trle_pkg::CFG_W'(1)) >= eff_width);
        close_first = (r_run_len != '0) && (pix_t != r_run_t);
        wr_addr     = close_first ? '0 : r_run_len;
        new_len     = wr_addr + trle_pkg::RUN_W'(1);
        full        = (new_len == RUN_FULL);
        has_b       = eol || full;

        a_hdr   = r_run_t ? (trle_pkg::TRANS_FLAG | {1'b0, r_run_len}) : {1'b0, r_run_len};
        a_lit_n = r_run_t ? '0 : r_run_len;

        // a transparent run closed by the row end has no header byte
        b_hdr_en = !pix_t || !eol;
        b_hdr    = pix_t ? (trle_pkg::TRANS_FLAG | {1'b0, new_len}) : {1'b0, new_len};
        b_lit_n  = pix_t ? '0 : new_len;
    end

    always_comb begin
        last_of_job = 1'b0;
        cur_byte    = trle_pkg::ROW_END_BYTE;
        unique case (r_state)
            S_HDR: begin
                cur_byte    = r_hdr;
                last_of_job = (r_lit_n == '0) && !r_eor;
            end
            S_LIT: begin
                cur_byte    = r_rd;
                last_of_job = (r_idx == (r_lit_n - trle_pkg::RUN_W'(1))) && !r_eor;
            end
            S_EOR: begin
                cur_byte    = trle_pkg::ROW_END_BYTE;
                last_of_job = 1'b1;
            end
            default: begin
                cur_byte    = trle_pkg::ROW_END_BYTE;
                last_of_job = 1'b0;
            end
        endcase
        final_byte = last_of_job && !r_b_pend;
        flush      = (r_pk_cnt == 3'd7) || final_byte;
        out_free   = !r_out_valid || i_m_axis_tready;
        emit       = (r_state != S_IDLE) && (!flush || out_free);
        pk_new     = r_pk | ({{(trle_pkg::WORD_W - trle_pkg::PIX_W){1'b0}}, cur_byte}
                             << {r_pk_cnt, 3'b000});
        cnt_new    = {1'b0, r_pk_cnt} + trle_pkg::CNT_W'(1);
        idx_next   = (r_idx == RUN_TOP) ? r_idx : (r_idx + trle_pkg::RUN_W'(1));
    end

    // literal read address: prefetch entry 0 during the header, then step on each byte
    always_comb begin
        if (r_state == S_LIT) begin
            rd_addr = emit ? idx_next : r_idx;
        end else begin
            rd_addr = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        if (accept) begin
            if (close_first) begin
                n_state = S_HDR;
            end else if (has_b) begin
                n_state = b_hdr_en ? S_HDR : S_EOR;
            end
        end else if (emit) begin
            if (last_of_job) begin
                if (r_b_pend) begin
                    n_state = r_b_hdr_en ? S_HDR : S_EOR;
                end else begin
                    n_state = S_IDLE;
                end
            end else begin
                unique case (r_state)
                    S_HDR:   n_state = (r_lit_n != '0) ? S_LIT : S_EOR;
                    S_LIT:   n_state = S_EOR;  // only reached after the last literal byte
                    default: n_state = r_state;
                endcase
                if (r_state == S_LIT && r_idx != (r_lit_n - trle_pkg::RUN_W'(1))) begin
                    n_state = S_LIT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !pix_t) begin
            r_mem[wr_addr] <= i_s_axis_tdata;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= trle_pkg::CFG_W'(1);
            r_col       <= '0;
            r_run_len   <= '0;
            r_run_t     <= 1'b0;
            r_state     <= S_IDLE;
            r_b_pend    <= 1'b0;
            r_idx       <= '0;
            r_pk        <= '0;
            r_pk_cnt    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_row_width <= i_cfg_wr_data;
            end

            r_state <= n_state;

            if (accept) begin
                r_run_t <= pix_t;
                if (eol) begin
                    r_col <= '0;
                end else begin
                    r_col <= r_col + trle_pkg::COL_W'(1);
                end
                r_run_len <= has_b ? '0 : new_len;

                r_b_hdr_en <= b_hdr_en;
                r_b_hdr    <= b_hdr;
                r_b_lit_n  <= b_lit_n;
                r_b_eor    <= eol;
                r_idx      <= '0;
                if (close_first) begin
                    r_hdr    <= a_hdr;
                    r_lit_n  <= a_lit_n;
                    r_eor    <= 1'b0;
                    r_b_pend <= has_b;
                end else if (has_b) begin
                    r_hdr    <= b_hdr;
                    r_lit_n  <= b_lit_n;
                    r_eor    <= eol;
                    r_b_pend <= 1'b0;
                end
            end else if (emit) begin
                if (last_of_job && r_b_pend) begin
                    r_hdr    <= r_b_hdr;
                    r_lit_n  <= r_b_lit_n;
                    r_eor    <= r_b_eor;
                    r_idx    <= '0;
                    r_b_pend <= 1'b0;
                end else if (r_state == S_LIT) begin
                    r_idx <= idx_next;
                end
            end

            // packer and output register
            if (emit && flush) begin
                r_pk        <= '0;
                r_pk_cnt    <= '0;
                r_out_valid <= 1'b1;
            end else begin
                if (emit) begin
                    r_pk     <= pk_new;
                    r_pk_cnt <= cnt_new[2:0];
                end
                if (i_m_axis_tready) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit && flush) begin
            r_out_data <= pk_new;
            r_out_cnt  <= cnt_new;
            r_out_last <= final_byte;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(trle_pkg::DATA_W - trle_pkg::WORD_W - trle_pkg::CNT_W){1'b0}},
                              r_out_cnt, r_out_data};
    assign o_m_axis_tlast  = r_out_last;

    // packer is empty whenever a new pixel may be taken
    a_idle_pk_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_pk_cnt == '0))
        else $error("packer holds bytes while idle");

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_b_pend)
        else $error("second close job left pending");

    a_lit_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIT) |-> (r_idx < r_lit_n))
        else $error("literal index past run length");

    a_run_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_len < RUN_FULL)
        else $error("open run reached full length");

endmodule

// ----- dv/transparent_run_length_encoder_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for transparent_run_length_encoder: directed rows, then random runs
// over a range of row widths, every coded word compared with a local encoder model or with a word given in the table.
// Depends on trle_pkg and the encoder RTL.
module transparent_run_length_encoder_tb;

    typedef enum logic {ROW_CFG, ROW_PIX} t_row_kind;

    typedef struct packed {
        t_row_kind                       kind;
        logic [trle_pkg::CFG_W-1:0]      value;   // row width or pixel
        bit                              typed;   // single coded word given below
        logic [trle_pkg::WORD_W-1:0]     word;
        logic [trle_pkg::CNT_W-1:0]      count;
    } t_stim_row;

    typedef struct packed {
        logic [trle_pkg::WORD_W-1:0] word;
        logic [trle_pkg::CNT_W-1:0]  count;
        logic                        last;
    } t_coded_word;

    localparam int N_DIR = 23;
    localparam t_stim_row DIR_ROWS [N_DIR] = '{
        '{ROW_PIX, 13'h000, 1'b1, 64'h80,     4'd1},  // width 1 after reset
        '{ROW_PIX, 13'h0ff, 1'b1, 64'h80ff01, 4'd3},
        '{ROW_PIX, 13'h001, 1'b1, 64'h800101, 4'd3},
        '{ROW_CFG, 13'h000, 1'b0, 64'h0,      4'd0},  // zero width acts as one
        '{ROW_PIX, 13'h000, 1'b1, 64'h80,     4'd1},
        '{ROW_PIX, 13'h080, 1'b1, 64'h808001, 4'd3},
        '{ROW_CFG, 13'h1fff, 1'b0, 64'h0,     4'd0},  // clamps to max width
        '{ROW_PIX, 13'h000, 1'b0, 64'h0,      4'd0},
        '{ROW_PIX, 13'h000, 1'b0, 64'h0,      4'd0},
        '{ROW_PIX, 13'h02a, 1'b0, 64'h0,      4'd0},
        '{ROW_CFG, 13'h004, 1'b0, 64'h0,      4'd0},  // column 3 now at row end
        '{ROW_PIX, 13'h02a, 1'b0, 64'h0,      4'd0},
        '{ROW_PIX, 13'h000, 1'b0, 64'h0,      4'd0},
        '{ROW_PIX, 13'h000, 1'b0, 64'h0,      4'd0},
        '{ROW_PIX, 13'h07f, 1'b0, 64'h0,      4'd0},
        '{ROW_PIX, 13'h000, 1'b0, 64'h0,      4'd0},
        '{ROW_CFG, 13'h003, 1'b0, 64'h0,      4'd0},
        '{ROW_PIX, 13'h011, 1'b0, 64'h0,      4'd0},
        '{ROW_PIX, 13'h000, 1'b0, 64'h0,      4'd0},
        '{ROW_PIX, 13'h0ff, 1'b0, 64'h0,      4'd0},
        '{ROW_PIX, 13'h005, 1'b0, 64'h0,      4'd0},
        '{ROW_CFG, 13'h001, 1'b0, 64'h0,      4'd0},  // shrink below current column
        '{ROW_PIX, 13'h006, 1'b0, 64'h0,      4'd0}
    };

    // random phases; width -1 picks a small random width
    localparam int N_PHASE = 11;
    localparam int PH_WIDTH [N_PHASE] = '{1, 127, 2, 300, 7, 4096, 0, 8191, 16, -1, 5};
    localparam int PH_COUNT [N_PHASE] = '{4, 0, 4, 4, 4, 4, 3, 3, 4, 4, 4};
    localparam int PH_LEAD  [N_PHASE] = '{0, 127, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    // full literal row of 127 is full at the row end and gives the longest burst
    localparam bit PH_LEAD_LIT [N_PHASE] = '{0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_wr_en = 1'b0;
    logic [trle_pkg::CFG_W-1:0]        i_cfg_wr_data = '0;
    logic                              i_s_axis_tvalid = 1'b0;
    logic                              o_s_axis_tready;
    logic [trle_pkg::PIX_W-1:0]        i_s_axis_tdata = '0;
    logic                              o_m_axis_tvalid;
    logic                              i_m_axis_tready = 1'b0;
    logic [trle_pkg::DATA_W-1:0]       o_m_axis_tdata;
    logic                              o_m_axis_tlast;

    transparent_run_length_encoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // encoder model state
    logic [trle_pkg::CFG_W-1:0]  enc_width = 13'd1;
    logic [trle_pkg::COL_W-1:0]  enc_col = '0;
    logic [trle_pkg::RUN_W-1:0]  enc_run = '0;
    bit                          enc_run_zero = 1'b0;
    logic [trle_pkg::PIX_W-1:0]  lit_store [trle_pkg::MAX_RUN];
    logic [trle_pkg::PIX_W-1:0]  coded_bytes [$];

    t_coded_word pending_words [$];
    t_coded_word exp_w;
    int send_idle_pct = 37;
    int recv_idle_pct = 79;
    int mismatches = 0;
    int words_checked = 0;
    int pixels_sent = 0;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    task automatic close_run(input bit at_row_end);
        int i;
        if (enc_run != 0) begin
            if (enc_run_zero) begin
                if (!at_row_end)
                    coded_bytes.push_back(trle_pkg::TRANS_FLAG + {1'b0, enc_run});
            end else begin
                coded_bytes.push_back({1'b0, enc_run});
                for (i = 0; i < enc_run; i++)
                    coded_bytes.push_back(lit_store[i]);
            end
            enc_run = '0;
        end
    endtask

    task automatic encode_pixel(input logic [trle_pkg::PIX_W-1:0] p);
        bit zero_px;
        int eff;
        zero_px = (p == 8'h00);
        eff = int'(enc_width);
        if (eff < 1)
            eff = 1;
        else if (eff > trle_pkg::MAX_WIDTH)
            eff = trle_pkg::MAX_WIDTH;
        coded_bytes.delete();
        if (enc_run != 0 && zero_px != enc_run_zero)
            close_run(1'b0);
        if (enc_run == 0)
            enc_run_zero = zero_px;
        if (enc_run < trle_pkg::MAX_RUN) begin
            if (!zero_px)
                lit_store[enc_run] = p;
            enc_run = enc_run + 1'b1;
        end
        if (int'(enc_col) + 1 >= eff) begin
            close_run(1'b1);
            coded_bytes.push_back(trle_pkg::ROW_END_BYTE);
            enc_col = '0;
        end else begin
            enc_col = enc_col + 1'b1;
            if (enc_run >= trle_pkg::MAX_RUN)
                close_run(1'b0);
        end
    endtask

    // one pixel request; queues its coded words once accepted
    task automatic send_pixel(input logic [trle_pkg::PIX_W-1:0] p, input bit typed,
                              input logic [trle_pkg::WORD_W-1:0] t_word,
                              input logic [trle_pkg::CNT_W-1:0] t_cnt);
        int k;
        int i;
        int n;
        t_coded_word w;
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= p;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        pixels_sent++;
        encode_pixel(p);
        if (typed) begin
            w.word  = t_word;
            w.count = t_cnt;
            w.last  = 1'b1;
            pending_words.push_back(w);
        end else begin
            for (k = 0; k < coded_bytes.size(); k += 8) begin
                n = coded_bytes.size() - k;
                if (n > 8)
                    n = 8;
                w.word = '0;
                for (i = 0; i < n; i++)
                    w.word[8*i +: 8] = coded_bytes[k+i];
                w.count = trle_pkg::CNT_W'(n);
                w.last  = (k + 8 >= coded_bytes.size());
                pending_words.push_back(w);
            end
        end
    endtask

    // width writes only with the encoder drained and quiet
    task automatic set_width(input logic [trle_pkg::CFG_W-1:0] wv);
        i_s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= wv;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        enc_width = wv;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (pending_words.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected coded word, expected none, got %h",
                             $time, o_m_axis_tdata);
                end else begin
                    exp_w = pending_words.pop_front();
                    words_checked++;
                    if (o_m_axis_tdata[trle_pkg::WORD_W-1:0] !== exp_w.word) begin
                        mismatches++;
                        $display("%0t: packed_bytes expected %h got %h", $time, exp_w.word,
                                 o_m_axis_tdata[trle_pkg::WORD_W-1:0]);
                    end
                    if (o_m_axis_tdata[trle_pkg::DATA_W-1:trle_pkg::WORD_W]
                            !== {4'b0, exp_w.count}) begin
                        mismatches++;
                        $display("%0t: byte_count expected %0d got %h", $time, exp_w.count,
                                 o_m_axis_tdata[trle_pkg::DATA_W-1:trle_pkg::WORD_W]);
                    end
                    if (o_m_axis_tlast !== exp_w.last) begin
                        mismatches++;
                        $display("%0t: last expected %b got %b", $time, exp_w.last,
                                 o_m_axis_tlast);
                    end
                end
            end
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        int r;
        int ph;
        int i;
        int remaining;
        int run_len;
        bit run_zero;
        logic [trle_pkg::CFG_W-1:0] wv;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < N_DIR; r++) begin
            if (DIR_ROWS[r].kind == ROW_CFG)
                set_width(DIR_ROWS[r].value);
            else
                send_pixel(DIR_ROWS[r].value[trle_pkg::PIX_W-1:0], DIR_ROWS[r].typed,
                           DIR_ROWS[r].word, DIR_ROWS[r].count);
        end

        for (ph = 0; ph < N_PHASE; ph++) begin
            if (ph == 4) begin
                send_idle_pct = 79;
                recv_idle_pct = 37;
            end else if (ph == 8) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wv = (PH_WIDTH[ph] < 0) ? trle_pkg::CFG_W'($urandom_range(1, 40))
                                    : trle_pkg::CFG_W'(PH_WIDTH[ph]);
            set_width(wv);

            run_zero = PH_LEAD_LIT[ph] ? 1'b0 : 1'($urandom_range(1));
            for (i = 0; i < PH_LEAD[ph]; i++)
                send_pixel(run_zero ? 8'h00 : 8'($urandom_range(1, 255)), 1'b0, '0, '0);

            remaining = PH_COUNT[ph];
            while (remaining > 0) begin
                if ($urandom_range(7) == 0) begin
                    // stray pixel of any value
                    send_pixel(8'($urandom_range(255)), 1'b0, '0, '0);
                    remaining--;
                end else begin
                    run_zero = 1'($urandom_range(1));
                    run_len = ($urandom_range(3) == 0) ? $urandom_range(1, 24)
                                                       : $urandom_range(1, 6);
                    for (i = 0; i < run_len && remaining > 0; i++) begin
                        send_pixel(run_zero ? 8'h00 : 8'($urandom_range(1, 255)),
                                   1'b0, '0, '0);
                        remaining--;
                    end
                end
            end
        end

        i_s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Encoded %0d pixels across %0d row-width settings incl. zero and clamped",
                 pixels_sent, N_PHASE + 5);
        $display("Checked %0d coded words, %0d mismatches", words_checked, mismatches);
        if (mismatches == 0 && pending_words.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/trle_pkg.sv
rtl/transparent_run_length_encoder.sv
dv/transparent_run_length_encoder_tb.sv
